### src/dra_pkg.sv
// ----------------------------------------------------------------------------
// dra_pkg: shared types and constants of the deferred-release id allocator
// holds the item formats, mode and status codes, and the cell geometry
// ----------------------------------------------------------------------------
`default_nettype none

package dra_pkg;

  // pool geometry
  localparam int NUM_SLOTS    = 128;
  localparam int ID_W         = 7;
  localparam int ID_SPACE     = 1 << ID_W;
  localparam int USABLE_SLOTS = (NUM_SLOTS < ID_SPACE) ? NUM_SLOTS : ID_SPACE;

  // each cell keeps the flags of a group of slots
  localparam int CELL_LOG  = 3;
  localparam int CELL_W    = 1 << CELL_LOG;
  localparam int NUM_CELLS = (NUM_SLOTS + CELL_W - 1) / CELL_W;
  localparam int CIDX_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int GSLOT_W   = CIDX_W + CELL_LOG;
  // one extra bit so the usable slot count itself fits the compare
  localparam int CMP_W     = ((GSLOT_W > ID_W) ? GSLOT_W : ID_W) + 1;

  typedef enum logic [1:0] {
    MODE_CREATE   = 2'd0,
    MODE_DESTROY  = 2'd1,
    MODE_VALIDATE = 2'd2,
    MODE_SWEEP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_MISS        = 2'd1,
    ST_BAD_DESTROY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    mode_e           mode;
    logic [ID_W-1:0] slot_id;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    status_e         status;
  } result_t;

  // broadcast command to every cell
  typedef struct packed {
    logic            apply;
    mode_e           mode;
    logic [ID_W-1:0] slot_id;
  } cell_cmd_t;

  // per-cell response
  typedef struct packed {
    logic                found;
    logic [CELL_LOG-1:0] bit_idx;
    logic                hit;
  } cell_rsp_t;

endpackage

`default_nettype wire

### src/dra_cell.sv
// ----------------------------------------------------------------------------
// dra_cell: flag cell of the id allocator
// keeps in-use and destroyed flags of one slot group, claims a slot when the
// search token arrives and passes the token on when the group is full
// ----------------------------------------------------------------------------
`default_nettype none

module dra_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [dra_pkg::CIDX_W-1:0] cell_idx_i,
  input  wire dra_pkg::cell_cmd_t         cmd_i,
  input  wire logic                       tok_i,
  output logic                            tok_o,
  output dra_pkg::cell_rsp_t              rsp_o
);

  logic [dra_pkg::CELL_W-1:0]   live_q, live_d;
  logic [dra_pkg::CELL_W-1:0]   quar_q, quar_d;
  logic                         tok_q;
  logic [dra_pkg::CELL_W-1:0]   usable;
  logic [dra_pkg::CELL_W-1:0]   free;
  logic [dra_pkg::CELL_LOG-1:0] first_free;
  logic [dra_pkg::CMP_W-1:0]    sid_ext;
  logic [dra_pkg::CELL_LOG-1:0] sel_bit;
  logic                         sel;
  logic                         hit;
  logic                         claim;

  // slot 0 stays reserved and slots past the id space are never handed out
  always_comb begin
    for (int b = 0; b < dra_pkg::CELL_W; b++) begin
      usable[b] = (dra_pkg::CMP_W'({cell_idx_i, dra_pkg::CELL_LOG'(b)})
                   < dra_pkg::CMP_W'(dra_pkg::USABLE_SLOTS))
                  && ({cell_idx_i, dra_pkg::CELL_LOG'(b)} != '0);
    end
  end

  assign free = ~live_q & ~quar_q & usable;

  // lowest free slot in the group
  always_comb begin
    first_free = '0;
    for (int b = dra_pkg::CELL_W - 1; b >= 0; b--) begin
      if (free[b]) begin
        first_free = dra_pkg::CELL_LOG'(b);
      end
    end
  end

  assign sid_ext = dra_pkg::CMP_W'(cmd_i.slot_id);
  assign sel_bit = cmd_i.slot_id[dra_pkg::CELL_LOG-1:0];
  assign sel     = sid_ext[dra_pkg::CMP_W-1:dra_pkg::CELL_LOG]
                   == (dra_pkg::CMP_W - dra_pkg::CELL_LOG)'(cell_idx_i);
  assign hit     = sel && usable[sel_bit] && live_q[sel_bit] && !quar_q[sel_bit];
  assign claim   = tok_q && (|free);

  always_comb begin
    live_d = live_q;
    quar_d = quar_q;
    if (claim) begin
      live_d[first_free] = 1'b1;
    end
    if (cmd_i.apply) begin
      case (cmd_i.mode)
        dra_pkg::MODE_DESTROY: begin
          if (hit) begin
            quar_d[sel_bit] = 1'b1;
          end
        end
        dra_pkg::MODE_SWEEP: begin
          // first sweep drops in-use, second drops destroyed
          live_d = live_q & ~quar_q;
          quar_d = quar_q & live_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      quar_q <= '0;
      tok_q  <= 1'b0;
    end else begin
      live_q <= live_d;
      quar_q <= quar_d;
      tok_q  <= tok_i;
    end
  end

  assign tok_o         = tok_q && !(|free);
  assign rsp_o.found   = claim;
  assign rsp_o.bit_idx = first_free;
  assign rsp_o.hit     = hit;

endmodule

`default_nettype wire

### src/deferred_release_id_allocator.sv
// ----------------------------------------------------------------------------
// deferred_release_id_allocator: slot id pool with two-frame quarantine
// create, destroy, validate and end-of-frame sweep over a row of flag cells
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low, and its result
// is shown on result_o for exactly one cycle with done_o high; the receiver
// cannot stall, so it must take every result in that cycle. Destroy,
// validate and sweep are answered in the cycle after the item is taken and
// may follow each other in every cycle. Create walks a search token along
// the row of NUM_CELLS cells, one group of eight slots per cycle: the first
// cell that has a free slot claims the lowest one and its result is
// registered, and a token that falls off the end of the row gives a miss.
// Busy is high while the token travels, and the next item can be taken in
// the cycle that shows the create result. Slot 0 is reserved and is never
// live.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_release_id_allocator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire dra_pkg::item_t   item_i,
  output logic                  busy,
  output logic                  done_o,
  output dra_pkg::result_t      result_o
);

  dra_pkg::state_e                  state_q, state_d;
  logic                             done_q, done_d;
  dra_pkg::result_t                 res_q, res_d;

  logic                             accept;
  logic                             inject;
  dra_pkg::cell_cmd_t               cmd;
  logic [dra_pkg::NUM_CELLS-1:0]    tok_in;
  logic [dra_pkg::NUM_CELLS-1:0]    tok_out;
  dra_pkg::cell_rsp_t               rsp [dra_pkg::NUM_CELLS];
  logic                             any_found;
  logic                             any_hit;
  logic                             miss;
  logic [dra_pkg::GSLOT_W-1:0]      found_idx;

  // ------------------------------------------------------------------------
  // control: next state
  // ------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dra_pkg::S_IDLE: begin
        if (inject) begin
          state_d = dra_pkg::S_SEARCH;
        end
      end
      dra_pkg::S_SEARCH: begin
        if (any_found || miss) begin
          state_d = dra_pkg::S_IDLE;
        end
      end
      default: state_d = dra_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------------
  // control: outputs
  // ------------------------------------------------------------------------
  always_comb begin
    busy        = (state_q == dra_pkg::S_SEARCH);
    accept      = start && (state_q == dra_pkg::S_IDLE);
    // create launches the search token at the head of the row
    inject      = accept && (item_i.mode == dra_pkg::MODE_CREATE);
    // the other modes are broadcast to every cell at once
    cmd.apply   = accept && (item_i.mode != dra_pkg::MODE_CREATE);
    cmd.mode    = item_i.mode;
    cmd.slot_id = item_i.slot_id;
  end

  // ------------------------------------------------------------------------
  // row of flag cells, token handed to the next cell each cycle
  // ------------------------------------------------------------------------
  assign tok_in[0] = inject;

  for (genvar c = 0; c < dra_pkg::NUM_CELLS; c++) begin : g_cell
    if (c > 0) begin : g_link
      assign tok_in[c] = tok_out[c-1];
    end
    dra_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (dra_pkg::CIDX_W'(c)),
      .cmd_i      (cmd),
      .tok_i      (tok_in[c]),
      .tok_o      (tok_out[c]),
      .rsp_o      (rsp[c])
    );
  end

  // token falling off the end of the row means the pool is exhausted
  assign miss = tok_out[dra_pkg::NUM_CELLS-1];

  // at most one cell claims and at most one cell matches the slot id
  always_comb begin
    any_found = 1'b0;
    any_hit   = 1'b0;
    found_idx = '0;
    for (int c = 0; c < dra_pkg::NUM_CELLS; c++) begin
      any_found = any_found | rsp[c].found;
      any_hit   = any_hit | rsp[c].hit;
      if (rsp[c].found) begin
        found_idx = found_idx | {dra_pkg::CIDX_W'(c), rsp[c].bit_idx};
      end
    end
  end

  // ------------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------------
  always_comb begin
    done_d = 1'b0;
    res_d  = res_q;
    if (state_q == dra_pkg::S_SEARCH) begin
      if (any_found) begin
        done_d          = 1'b1;
        res_d.result_id = dra_pkg::ID_W'(found_idx);
        res_d.status    = dra_pkg::ST_OK;
      end else if (miss) begin
        done_d          = 1'b1;
        res_d.result_id = '0;
        res_d.status    = dra_pkg::ST_MISS;
      end
    end else if (cmd.apply) begin
      done_d = 1'b1;
      case (item_i.mode)
        dra_pkg::MODE_DESTROY: begin
          res_d.result_id = '0;
          res_d.status    = any_hit ? dra_pkg::ST_OK : dra_pkg::ST_BAD_DESTROY;
        end
        dra_pkg::MODE_VALIDATE: begin
          res_d.result_id = item_i.slot_id;
          res_d.status    = any_hit ? dra_pkg::ST_OK : dra_pkg::ST_MISS;
        end
        default: begin
          res_d.result_id = '0;
          res_d.status    = dra_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dra_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### src/dra_checker.sv
// ----------------------------------------------------------------------------
// dra_checker: port-level checks of the id allocator
// watches the command handshake and the result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module dra_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire dra_pkg::item_t   item_i,
  input wire logic             busy,
  input wire logic             done_o,
  input wire dra_pkg::result_t result_o
);

  // no result while a search is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result strobe while busy");

  // destroy, validate and sweep answer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode != dra_pkg::MODE_CREATE) |=> (done_o && !busy))
    else $error("immediate item not answered next cycle");

  // create always starts a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == dra_pkg::MODE_CREATE) |=> (busy && !done_o))
    else $error("create did not start a search");

  // end of a search delivers its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("search ended without a result");

  // a refused destroy carries id zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == dra_pkg::ST_BAD_DESTROY) |-> (result_o.result_id == '0))
    else $error("bad destroy with nonzero id");

endmodule

bind deferred_release_id_allocator dra_checker u_dra_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .item_i   (item_i),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the deferred-release id allocator
// runs a short table of directed items, then fills the pool to exhaustion,
// then random create, destroy, validate and sweep traffic under varying
// sender idling; results are checked against the table or a bit-level predictor
// ----------------------------------------------------------------------------

module testbench;
  import dra_pkg::*;

  // one row of the directed table
  typedef struct {
    item_t   req;
    bit      typed;   // want holds a hand-written result
    result_t want;
  } step_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  item_t   item_i;
  logic    busy;
  logic    done_o;
  result_t result_o;

  // predicted pool flags: in use, and destroyed (in quarantine)
  bit [NUM_SLOTS-1:0] in_use;
  bit [NUM_SLOTS-1:0] destroyed;

  result_t outstanding_results[$];
  step_t   script[$];
  result_t oldest;
  int      idle_pct;
  int      err_count;

  deferred_release_id_allocator u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // a slot is live when usable, not reserved, in use and not destroyed
  function automatic bit slot_live(logic [ID_W-1:0] id);
    return (id != '0) && (int'(id) < USABLE_SLOTS) && in_use[id] && !destroyed[id];
  endfunction

  // applies one item to the predicted pool and returns the result it gives
  function automatic result_t apply_to_pool(item_t it);
    result_t r;
    bit      found;
    r.result_id = '0;
    r.status    = ST_OK;
    found       = 1'b0;
    case (it.mode)
      MODE_CREATE: begin
        // lowest slot with both flags clear; slot 0 stays in use forever
        r.status = ST_MISS;
        for (int s = 0; s < USABLE_SLOTS; s++) begin
          if (!found && !in_use[s] && !destroyed[s]) begin
            found       = 1'b1;
            in_use[s]   = 1'b1;
            r.result_id = ID_W'(s);
            r.status    = ST_OK;
          end
        end
      end
      MODE_DESTROY: begin
        if (slot_live(it.slot_id)) destroyed[it.slot_id] = 1'b1;
        else r.status = ST_BAD_DESTROY;
      end
      MODE_VALIDATE: begin
        r.result_id = it.slot_id;
        r.status    = slot_live(it.slot_id) ? ST_OK : ST_MISS;
      end
      default: begin
        // sweep: first frame drops in-use, second frame drops destroyed
        destroyed = destroyed & in_use;
        in_use    = in_use & ~(destroyed);
      end
    endcase
    return r;
  endfunction

  // random slot that is live, or in quarantine; random slot if none is
  function automatic logic [ID_W-1:0] pick_slot(bit want_live);
    int base;
    int s;
    base = $urandom_range(NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = (base + k) % NUM_SLOTS;
      if (want_live ? slot_live(ID_W'(s)) : destroyed[s]) return ID_W'(s);
    end
    return ID_W'($urandom_range(ID_SPACE - 1));
  endfunction

  // mostly meaningful requests, with some noise slots mixed in
  function automatic item_t random_request();
    item_t it;
    int    roll;
    roll       = $urandom_range(99);
    it.slot_id = ID_W'($urandom_range(ID_SPACE - 1));
    if (roll < 30) begin
      it.mode = MODE_CREATE;
    end else if (roll < 58) begin
      it.mode = MODE_DESTROY;
      if ($urandom_range(4) != 0) it.slot_id = pick_slot(1'b1);
    end else if (roll < 85) begin
      it.mode = MODE_VALIDATE;
      case ($urandom_range(3))
        0, 1: it.slot_id = pick_slot(1'b1);
        2: it.slot_id = pick_slot(1'b0);
        default: ;
      endcase
    end else begin
      it.mode = MODE_SWEEP;
    end
    return it;
  endfunction

  function automatic void add_step(mode_e m, int slot, bit typed, int rid, status_e st);
    step_t row;
    row.req.mode       = m;
    row.req.slot_id    = ID_W'(slot);
    row.typed          = typed;
    row.want.result_id = ID_W'(rid);
    row.want.status    = st;
    script.push_back(row);
  endfunction

  // offers one item until taken, records its result, then maybe idles
  task automatic issue(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predicted = apply_to_pool(it);
    outstanding_results.push_back(typed ? want : predicted);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // holds the sender off until every result is in, then for longer than a full search
  task automatic drain();
    start <= 1'b0;
    while (outstanding_results.size() != 0) @(posedge clk_i);
    repeat (NUM_CELLS + 4) @(posedge clk_i);
  endtask

  // result checker: every strobe must match the oldest outstanding result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outstanding_results.size() == 0) begin
        $error("unexpected result: result_id %0d status %0d",
               result_o.result_id, result_o.status);
        err_count++;
      end else begin
        oldest = outstanding_results.pop_front();
        if (result_o.result_id !== oldest.result_id) begin
          $error("result_id: expected %0d, got %0d", oldest.result_id, result_o.result_id);
          err_count++;
        end
        if (result_o.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, result_o.status);
          err_count++;
        end
      end
    end
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    item_t fill_req;
    // directed table: mode, slot, typed, result_id, status
    add_step(MODE_VALIDATE, 0,   1, 0,   ST_MISS);         // reserved slot
    add_step(MODE_DESTROY,  0,   1, 0,   ST_BAD_DESTROY);  // reserved slot
    add_step(MODE_CREATE,   127, 1, 1,   ST_OK);           // slot field ignored
    add_step(MODE_CREATE,   0,   1, 2,   ST_OK);
    add_step(MODE_VALIDATE, 1,   1, 1,   ST_OK);
    add_step(MODE_VALIDATE, 127, 1, 127, ST_MISS);         // never allocated
    add_step(MODE_DESTROY,  127, 1, 0,   ST_BAD_DESTROY);  // never allocated
    add_step(MODE_DESTROY,  1,   1, 0,   ST_OK);
    add_step(MODE_VALIDATE, 1,   1, 1,   ST_MISS);         // destroyed is not live
    add_step(MODE_DESTROY,  1,   1, 0,   ST_BAD_DESTROY);  // double destroy
    add_step(MODE_CREATE,   85,  1, 3,   ST_OK);           // slot 1 in quarantine
    add_step(MODE_SWEEP,    42,  1, 0,   ST_OK);
    add_step(MODE_CREATE,   0,   1, 4,   ST_OK);           // one frame not enough
    add_step(MODE_SWEEP,    127, 1, 0,   ST_OK);
    add_step(MODE_CREATE,   0,   1, 1,   ST_OK);           // slot 1 is free again
    add_step(MODE_VALIDATE, 2,   0, 0,   ST_OK);
    add_step(MODE_DESTROY,  2,   0, 0,   ST_OK);
    add_step(MODE_SWEEP,    0,   0, 0,   ST_OK);
    add_step(MODE_VALIDATE, 2,   0, 0,   ST_OK);
    add_step(MODE_DESTROY,  4,   0, 0,   ST_OK);
    add_step(MODE_VALIDATE, 85,  0, 0,   ST_OK);

    // pool state right after reset
    in_use    = '0;
    in_use[0] = 1'b1;
    destroyed = '0;
    err_count = 0;
    idle_pct  = 27;

    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, sender idling lightly
    foreach (script[i]) issue(script[i].req, script[i].typed, script[i].want);

    // fill the pool until creates run dry, so the full search is exercised
    for (int n = 0; n < 135; n++) begin
      fill_req.mode    = MODE_CREATE;
      fill_req.slot_id = ID_W'($urandom_range(ID_SPACE - 1));
      issue(fill_req, 1'b0, '0);
    end
    drain();

    // random traffic: light sender idling
    repeat (150) issue(random_request(), 1'b0, '0);

    // heavy sender idling
    idle_pct = 88;
    repeat (150) issue(random_request(), 1'b0, '0);
    drain();

    // back to back
    idle_pct = 0;
    repeat (120) issue(random_request(), 1'b0, '0);

    // let the last results come out, then a margin for any stray strobe
    drain();
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/dra_pkg.sv
src/dra_cell.sv
src/deferred_release_id_allocator.sv
src/dra_checker.sv
verif/testbench.sv
